// ===== hdl/dtq_pkg.sv =====
`default_nettype none

package dtq_pkg;

    // Defaults for the top-level parameters.
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 8;
    localparam int DELTA_WIDTH_DEF = 32;

    // Fixed port widths.
    localparam int MODE_W     = 2;
    localparam int ID_PORT_W  = 8;
    localparam int EXP_PORT_W = 32;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;

    // Command codes.
    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXP  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_ZERO   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DUP    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ABSENT = 3'd4;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CHK,
        ST_ADD_NEG,
        ST_SHF_RD,
        ST_SHF_WR,
        ST_ADD_INS,
        ST_DEL_RD,
        ST_DEL_CHK,
        ST_RM_RD,
        ST_RM_WR,
        ST_TCK_RD,
        ST_TCK_DEC,
        ST_HD_RD,
        ST_HD_CHK
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/delta_timer_queue_unit.sv =====
`default_nettype none

// Delta-list timer queue. A command is taken on a rising edge with start high
// and busy low: i_mode selects add, delete or tick, i_timer_id names the timer
// and i_expires gives the ticks to expiry for an add. Mode 3 is dropped.
// Each result is shown for exactly one cycle with o_result_valid high; o_last
// marks the final result of a command. Add and delete give one result, a tick
// gives one result per expired timer, or a single no-expiry result.
// Entries sit in a single-port-read memory with registered read data and one
// shared adder-subtractor; every list step is a read state then a use state.
// An add scans all N live entries, negates the successor's delta when there is
// one, moves the entries behind the insertion point up by one (reading and
// rewriting each, plus a final read) and writes the new one. A delete scans
// up to the match and closes the gap behind it. A tick reads the head and
// decrements it unless already zero, then removes each expired entry. The
// sequencer is the limit; busy stays high until the command's last beat,
// which leaves in the same cycle as busy falls. The receiver cannot stall, so
// results never wait. Reset empties the queue at once; no clearing pass.
module delta_timer_queue_unit #(
    parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = dtq_pkg::ID_WIDTH_DEF,
    parameter int DELTA_WIDTH = dtq_pkg::DELTA_WIDTH_DEF
) (
    input  wire  logic                               i_clk,
    input  wire  logic                               i_rst_n,
    input  wire  logic                               start,
    output logic                                     busy,
    input  wire  logic [dtq_pkg::MODE_W-1:0]         i_mode,
    input  wire  logic [dtq_pkg::ID_PORT_W-1:0]      i_timer_id,
    input  wire  logic [dtq_pkg::EXP_PORT_W-1:0]     i_expires,
    output logic                                     o_result_valid,
    output logic [dtq_pkg::KIND_W-1:0]               o_kind,
    output logic [dtq_pkg::ID_PORT_W-1:0]            o_expired_or_acked_id,
    output logic [dtq_pkg::STATUS_W-1:0]             o_status,
    output logic                                     o_last
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int WW = ID_WIDTH + DELTA_WIDTH;

    dtq_pkg::t_state r_state, n_state;

    logic [dtq_pkg::MODE_W-1:0]    r_mode, n_mode;
    logic [ID_WIDTH-1:0]           r_id, n_id;
    logic [ID_WIDTH-1:0]           r_pend, n_pend;
    logic [DELTA_WIDTH-1:0]        r_rem, n_rem;
    logic [DELTA_WIDTH-1:0]        r_succ, n_succ;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_idx, n_idx;
    logic [CW-1:0]                 r_pos, n_pos;
    logic                          r_pos_set, n_pos_set;

    logic                          r_ov, n_ov;
    logic [dtq_pkg::KIND_W-1:0]    r_okind, n_okind;
    logic [dtq_pkg::ID_PORT_W-1:0] r_oid, n_oid;
    logic [dtq_pkg::STATUS_W-1:0]  r_ostat, n_ostat;
    logic                          r_olast, n_olast;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [WW-1:0]                 mem_wdata;
    logic [AW-1:0]                 mem_raddr;
    logic [WW-1:0]                 mem_rdata;
    logic [ID_WIDTH-1:0]           rd_id;
    logic [DELTA_WIDTH-1:0]        rd_delta;

    dtq_pkg::t_alu_op              alu_op;
    logic [DELTA_WIDTH-1:0]        alu_a, alu_b, alu_y;
    logic                          alu_carry;

    logic [DELTA_WIDTH-1:0]        exp_in;
    logic [ID_WIDTH-1:0]           id_in;
    logic [CW-1:0]                 idx_inc, idx_dec;
    logic                          scan_end, full, id_match, sh_end, rm_end;
    logic                          head_zero, tick_zero, last_pop;

    dtq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (WW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    dtq_alu #(
        .WIDTH (DELTA_WIDTH)
    ) u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_y     (alu_y),
        .o_carry (alu_carry)
    );

    assign rd_id    = mem_rdata[WW-1:DELTA_WIDTH];
    assign rd_delta = mem_rdata[DELTA_WIDTH-1:0];

    assign exp_in    = DELTA_WIDTH'(i_expires);
    assign id_in     = ID_WIDTH'(i_timer_id);
    assign idx_inc   = r_idx + CW'(1);
    assign idx_dec   = r_idx - CW'(1);
    assign scan_end  = (r_idx == r_count);
    assign full      = (r_count == CW'(QUEUE_DEPTH));
    assign id_match  = (rd_id == r_id);
    assign sh_end    = (r_idx == r_pos);
    assign rm_end    = (idx_inc >= r_count);
    assign head_zero = (rd_delta == '0);
    assign tick_zero = head_zero || (alu_y == '0);
    assign last_pop  = (r_count == CW'(1));

    assign busy = (r_state != dtq_pkg::ST_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dtq_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_mode)
                        dtq_pkg::MODE_ADD: begin
                            if (exp_in != '0) begin
                                n_state = dtq_pkg::ST_ADD_RD;
                            end
                        end
                        dtq_pkg::MODE_DEL: n_state = dtq_pkg::ST_DEL_RD;
                        dtq_pkg::MODE_TICK: begin
                            if (r_count != '0) begin
                                n_state = dtq_pkg::ST_TCK_RD;
                            end
                        end
                        default: n_state = dtq_pkg::ST_IDLE;
                    endcase
                end
            end
            dtq_pkg::ST_ADD_RD: begin
                if (!scan_end) begin
                    n_state = dtq_pkg::ST_ADD_CHK;
                end else if (full) begin
                    n_state = dtq_pkg::ST_IDLE;
                end else if (r_pos_set) begin
                    n_state = dtq_pkg::ST_ADD_NEG;
                end else begin
                    n_state = dtq_pkg::ST_SHF_RD;
                end
            end
            dtq_pkg::ST_ADD_CHK: begin
                n_state = id_match ? dtq_pkg::ST_IDLE : dtq_pkg::ST_ADD_RD;
            end
            dtq_pkg::ST_ADD_NEG: n_state = dtq_pkg::ST_SHF_RD;
            dtq_pkg::ST_SHF_RD: begin
                n_state = sh_end ? dtq_pkg::ST_ADD_INS : dtq_pkg::ST_SHF_WR;
            end
            dtq_pkg::ST_SHF_WR:  n_state = dtq_pkg::ST_SHF_RD;
            dtq_pkg::ST_ADD_INS: n_state = dtq_pkg::ST_IDLE;
            dtq_pkg::ST_DEL_RD: begin
                n_state = scan_end ? dtq_pkg::ST_IDLE : dtq_pkg::ST_DEL_CHK;
            end
            dtq_pkg::ST_DEL_CHK: begin
                n_state = id_match ? dtq_pkg::ST_RM_RD : dtq_pkg::ST_DEL_RD;
            end
            dtq_pkg::ST_RM_RD: begin
                if (!rm_end) begin
                    n_state = dtq_pkg::ST_RM_WR;
                end else if (r_mode == dtq_pkg::MODE_DEL || last_pop) begin
                    n_state = dtq_pkg::ST_IDLE;
                end else begin
                    n_state = dtq_pkg::ST_HD_RD;
                end
            end
            dtq_pkg::ST_RM_WR:  n_state = dtq_pkg::ST_RM_RD;
            dtq_pkg::ST_TCK_RD: n_state = dtq_pkg::ST_TCK_DEC;
            dtq_pkg::ST_TCK_DEC: begin
                n_state = tick_zero ? dtq_pkg::ST_RM_RD : dtq_pkg::ST_IDLE;
            end
            dtq_pkg::ST_HD_RD: n_state = dtq_pkg::ST_HD_CHK;
            dtq_pkg::ST_HD_CHK: begin
                n_state = head_zero ? dtq_pkg::ST_RM_RD : dtq_pkg::ST_IDLE;
            end
            default: n_state = dtq_pkg::ST_IDLE;
        endcase
    end

    // Datapath control, memory and ALU steering, result beats.
    always_comb begin
        n_mode    = r_mode;
        n_id      = r_id;
        n_pend    = r_pend;
        n_rem     = r_rem;
        n_succ    = r_succ;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_pos_set = r_pos_set;
        n_ov      = 1'b0;
        n_okind   = r_okind;
        n_oid     = r_oid;
        n_ostat   = r_ostat;
        n_olast   = r_olast;
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = r_idx[AW-1:0];
        alu_op    = dtq_pkg::ALU_SUB;
        alu_a     = r_rem;
        alu_b     = rd_delta;
        case (r_state)
            dtq_pkg::ST_IDLE: begin
                if (start) begin
                    n_mode    = i_mode;
                    n_id      = id_in;
                    n_rem     = exp_in;
                    n_idx     = '0;
                    n_pos     = '0;
                    n_pos_set = 1'b0;
                    if (i_mode == dtq_pkg::MODE_ADD && exp_in == '0) begin
                        n_ov    = 1'b1;
                        n_okind = dtq_pkg::KIND_ADD;
                        n_oid   = dtq_pkg::ID_PORT_W'(id_in);
                        n_ostat = dtq_pkg::STAT_ZERO;
                        n_olast = 1'b1;
                    end else if (i_mode == dtq_pkg::MODE_TICK && r_count == '0) begin
                        n_ov    = 1'b1;
                        n_okind = dtq_pkg::KIND_NONE;
                        n_oid   = '0;
                        n_ostat = dtq_pkg::STAT_OK;
                        n_olast = 1'b1;
                    end
                end
            end
            dtq_pkg::ST_ADD_RD: begin
                if (scan_end) begin
                    n_idx = r_count;
                    if (full) begin
                        n_ov    = 1'b1;
                        n_okind = dtq_pkg::KIND_ADD;
                        n_oid   = dtq_pkg::ID_PORT_W'(r_id);
                        n_ostat = dtq_pkg::STAT_FULL;
                        n_olast = 1'b1;
                    end else if (!r_pos_set) begin
                        n_pos = r_count;
                    end
                end
            end
            dtq_pkg::ST_ADD_CHK: begin
                if (id_match) begin
                    n_ov    = 1'b1;
                    n_okind = dtq_pkg::KIND_ADD;
                    n_oid   = dtq_pkg::ID_PORT_W'(r_id);
                    n_ostat = dtq_pkg::STAT_DUP;
                    n_olast = 1'b1;
                end else begin
                    // The walk stops at the first entry whose delta is strictly
                    // larger; the scan still runs on to catch a duplicate id.
                    if (!r_pos_set) begin
                        if (alu_carry) begin
                            n_pos     = r_idx;
                            n_pos_set = 1'b1;
                            n_succ    = alu_y;
                        end else begin
                            n_rem = alu_y;
                        end
                    end
                    n_idx = idx_inc;
                end
            end
            dtq_pkg::ST_ADD_NEG: begin
                // The stored difference is remaining minus delta; negate it.
                alu_a  = '0;
                alu_b  = r_succ;
                n_succ = alu_y;
            end
            dtq_pkg::ST_SHF_RD: begin
                mem_raddr = idx_dec[AW-1:0];
            end
            dtq_pkg::ST_SHF_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                if (idx_dec == r_pos) begin
                    mem_wdata = {rd_id, r_succ};
                end
                n_idx = idx_dec;
            end
            dtq_pkg::ST_ADD_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[AW-1:0];
                mem_wdata = {r_id, r_rem};
                n_count   = r_count + CW'(1);
                n_ov      = 1'b1;
                n_okind   = dtq_pkg::KIND_ADD;
                n_oid     = dtq_pkg::ID_PORT_W'(r_id);
                n_ostat   = dtq_pkg::STAT_OK;
                n_olast   = 1'b1;
            end
            dtq_pkg::ST_DEL_RD: begin
                if (scan_end) begin
                    n_ov    = 1'b1;
                    n_okind = dtq_pkg::KIND_DEL;
                    n_oid   = dtq_pkg::ID_PORT_W'(r_id);
                    n_ostat = dtq_pkg::STAT_ABSENT;
                    n_olast = 1'b1;
                end
            end
            dtq_pkg::ST_DEL_CHK: begin
                if (id_match) begin
                    n_pos = r_idx;
                    n_rem = rd_delta;
                end else begin
                    n_idx = idx_inc;
                end
            end
            dtq_pkg::ST_RM_RD: begin
                mem_raddr = idx_inc[AW-1:0];
                if (rm_end) begin
                    n_count = r_count - CW'(1);
                    if (r_mode == dtq_pkg::MODE_DEL) begin
                        n_ov    = 1'b1;
                        n_okind = dtq_pkg::KIND_DEL;
                        n_oid   = dtq_pkg::ID_PORT_W'(r_id);
                        n_ostat = dtq_pkg::STAT_OK;
                        n_olast = 1'b1;
                    end else if (last_pop) begin
                        n_ov    = 1'b1;
                        n_okind = dtq_pkg::KIND_EXP;
                        n_oid   = dtq_pkg::ID_PORT_W'(r_pend);
                        n_ostat = dtq_pkg::STAT_OK;
                        n_olast = 1'b1;
                    end
                end
            end
            dtq_pkg::ST_RM_WR: begin
                // The successor of the removed entry inherits its delta.
                alu_op    = dtq_pkg::ALU_ADD;
                alu_a     = rd_delta;
                alu_b     = r_rem;
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = {rd_id, (r_idx == r_pos) ? alu_y : rd_delta};
                n_idx     = idx_inc;
            end
            dtq_pkg::ST_TCK_RD: begin
                mem_raddr = '0;
            end
            dtq_pkg::ST_TCK_DEC: begin
                // A head already at zero is not decremented.
                alu_a     = rd_delta;
                alu_b     = DELTA_WIDTH'(1);
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {rd_id, head_zero ? rd_delta : alu_y};
                if (tick_zero) begin
                    n_pend = rd_id;
                    n_pos  = '0;
                    n_idx  = '0;
                    n_rem  = '0;
                end else begin
                    n_ov    = 1'b1;
                    n_okind = dtq_pkg::KIND_NONE;
                    n_oid   = '0;
                    n_ostat = dtq_pkg::STAT_OK;
                    n_olast = 1'b1;
                end
            end
            dtq_pkg::ST_HD_RD: begin
                mem_raddr = '0;
            end
            dtq_pkg::ST_HD_CHK: begin
                // The pending expiry leaves only once it is known whether
                // another one follows, so that its last flag is right.
                n_ov    = 1'b1;
                n_okind = dtq_pkg::KIND_EXP;
                n_oid   = dtq_pkg::ID_PORT_W'(r_pend);
                n_ostat = dtq_pkg::STAT_OK;
                n_olast = !head_zero;
                if (head_zero) begin
                    n_pend = rd_id;
                    n_pos  = '0;
                    n_idx  = '0;
                    n_rem  = '0;
                end
            end
            default: begin
                n_ov = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtq_pkg::ST_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_id      <= n_id;
        r_pend    <= n_pend;
        r_rem     <= n_rem;
        r_succ    <= n_succ;
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_pos_set <= n_pos_set;
        r_okind   <= n_okind;
        r_oid     <= n_oid;
        r_ostat   <= n_ostat;
        r_olast   <= n_olast;
    end

    assign o_result_valid        = r_ov;
    assign o_kind                = r_okind;
    assign o_expired_or_acked_id = r_oid;
    assign o_status              = r_ostat;
    assign o_last                = r_olast;

endmodule

`default_nettype wire

// ===== hdl/dtq_alu.sv =====
`default_nettype none

module dtq_alu #(
    parameter int WIDTH = dtq_pkg::DELTA_WIDTH_DEF
) (
    input  var   dtq_pkg::t_alu_op i_op,
    input  wire  logic [WIDTH-1:0] i_a,
    input  wire  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0]       o_y,
    output logic                   o_carry
);

    logic [WIDTH:0] sum;

    // For a subtraction the top bit is the borrow.
    always_comb begin
        case (i_op)
            dtq_pkg::ALU_ADD: sum = {1'b0, i_a} + {1'b0, i_b};
            dtq_pkg::ALU_SUB: sum = {1'b0, i_a} - {1'b0, i_b};
            default:          sum = '0;
        endcase
    end

    assign o_y     = sum[WIDTH-1:0];
    assign o_carry = sum[WIDTH];

endmodule

`default_nettype wire

// ===== hdl/dtq_mem.sv =====
`default_nettype none

module dtq_mem #(
    parameter  int DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
    parameter  int WIDTH = dtq_pkg::ID_WIDTH_DEF + dtq_pkg::DELTA_WIDTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire  logic             i_clk,
    input  wire  logic             i_we,
    input  wire  logic [AW-1:0]    i_waddr,
    input  wire  logic [WIDTH-1:0] i_wdata,
    input  wire  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0]       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
